[hw/rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS      = 64;
  localparam int unsigned HEADER_BYTES    = 40;
  localparam int unsigned ALIGN_BYTES     = 16;  // power of two
  localparam int unsigned MIN_BLOCK_BYTES = 16;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned ALU_W     = ADDR_W + 2;
  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ALU_W-1:0]  wide_t;

  // Rounding constants for the aligned data address
  localparam wide_t ROUND_ADD  = wide_t'(HEADER_BYTES + ALIGN_BYTES - 1);
  localparam wide_t ALIGN_MASK = ~wide_t'(ALIGN_BYTES - 1);
  localparam wide_t MIN_W      = wide_t'(MIN_BLOCK_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_START = 2'd0,
    REG_HEAP_END   = 2'd1
  } reg_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_NO_FIT  = 2'd2
  } status_e;

  typedef struct packed {
    addr_t start;
    addr_t size;
  } entry_t;

  typedef struct packed {
    wide_t a;
    wide_t b;
    wide_t c;
    logic  sub;
  } alu_req_t;

  typedef struct packed {
    wide_t r;
    logic  lt;
    logic  gt;
  } alu_rsp_t;

  function automatic wide_t widen(addr_t x);
    return {{(ALU_W - ADDR_W){1'b0}}, x};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ffha_if.sv]
`default_nettype none
interface ffha_cmd_if;
  logic                valid;
  logic                ready;
  logic                command;
  ffha_pkg::addr_t     request_bytes;
  ffha_pkg::addr_t     free_address;
  modport source(output valid, command, request_bytes, free_address, input ready);
  modport sink(input valid, command, request_bytes, free_address, output ready);
endinterface

interface ffha_res_if;
  logic                valid;
  logic                ready;
  ffha_pkg::addr_t     block_address;
  logic [1:0]          status;
  modport source(output valid, block_address, status, input ready);
  modport sink(input valid, block_address, status, output ready);
endinterface

interface ffha_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ffha_pkg::CFG_IDX_W-1:0]   index;
  ffha_pkg::addr_t                  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/ffha_alu.sv]
`default_nettype none
module ffha_alu (
  input  ffha_pkg::alu_req_t req_i,
  output ffha_pkg::alu_rsp_t rsp_o
);

  ffha_pkg::wide_t r;

  // One shared add/subtract followed by a compare against the third operand
  always_comb begin
    r        = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
    rsp_o.r  = r;
    rsp_o.lt = r < req_i.c;
    rsp_o.gt = r > req_i.c;
  end

endmodule
`default_nettype wire

[hw/rtl/ffha_table.sv]
`default_nettype none
module ffha_table (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ffha_pkg::IDX_W-1:0]    waddr_i,
  input  ffha_pkg::entry_t              wdata_i,
  input  logic                          re_i,
  input  logic [ffha_pkg::IDX_W-1:0]    raddr_i,
  output ffha_pkg::entry_t              rdata_o
);

  ffha_pkg::entry_t mem_q [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rdata_q;

  // One write and one registered read per cycle; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/first_fit_heap_allocator_unit.sv]
`default_nettype none
// Channel   Dir  Payload                                  Beat taken when
// cfg_i     in   index, data (heap_start / heap_end)      valid & ready
// cmd_i     in   command, request_bytes, free_address     valid & ready
// res_o     out  block_address, status                    valid & ready
//
// One command at a time through a shared adder/comparator and a table memory with one
// registered read port. An allocate scan reads each entry in turn, skips used ones and tests
// free ones for fit; a split shifts later entries up by one and writes the remainder. A free
// scans for the block, merges with a free next and previous block and moves entries down.
// A bound write rebuilds the table as one free block; after reset every command is refused.
// A result waits in the output register; the next finished one stalls until it drains.
module first_fit_heap_allocator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffha_cfg_if.sink     cfg_i,
  ffha_cmd_if.sink     cmd_i,
  ffha_res_if.source   res_o
);

  localparam int unsigned W  = ffha_pkg::ADDR_W;
  localparam int unsigned IW = ffha_pkg::IDX_W;
  localparam int unsigned CW = ffha_pkg::CNT_W;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT_A, S_INIT_B, S_INIT_C, S_CHK,
    S_SC_RD, S_SC_EV, S_SC_EV2,
    S_SPL_A, S_SPL_B, S_SPL_C, S_SPL_D, S_SPL_E, S_INS_RD, S_INS_WR,
    S_FR_RD, S_FR_EV, S_NX_RD, S_NX_A, S_NX_B,
    S_RM_RD, S_RM_WR, S_PV_CHK, S_PV_A, S_PV_B, S_DONE
  } state_e;

  state_e                   state_q;
  ffha_pkg::addr_t          hs_q, he_q, usable_q, req_q, faddr_q, st_q, sz_q;
  ffha_pkg::wide_t          a_q, end_q, tmp_q;
  logic                     ready_q, phase_q;
  logic [CW-1:0]            count_q, idx_q, k_q;
  logic [ffha_pkg::MAX_BLOCKS-1:0] used_q;
  ffha_pkg::addr_t          res_addr_q, out_addr_q;
  ffha_pkg::status_e        res_stat_q, out_stat_q;
  logic                     out_valid_q;

  ffha_pkg::alu_req_t       alu_req;
  ffha_pkg::alu_rsp_t       alu_rsp;
  logic                     we, re;
  logic [IW-1:0]            waddr, raddr;
  ffha_pkg::entry_t         wdata, rd;
  logic [CW-1:0]            idx_p1, idx_m1, k_p1, k_m1;
  logic                     cmd_fire, cfg_fire, split;

  ffha_alu u_alu (.req_i(alu_req), .rsp_o(alu_rsp));

  ffha_table u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rd)
  );

  assign idx_p1 = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);
  assign k_p1   = k_q + CW'(1);
  assign k_m1   = k_q - CW'(1);

  assign cfg_i.ready = (state_q == S_IDLE);
  assign cmd_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  assign res_o.valid         = out_valid_q;
  assign res_o.block_address = out_addr_q;
  assign res_o.status        = out_stat_q;

  assign split = alu_rsp.lt && (count_q < CW'(ffha_pkg::MAX_BLOCKS));

  // Drive the shared unit and the table port from the current step
  always_comb begin
    alu_req = '0;
    we      = 1'b0;
    waddr   = '0;
    wdata   = '0;
    re      = 1'b0;
    raddr   = '0;
    unique case (state_q)
      S_IDLE, S_DONE, S_FR_EV: begin
      end
      S_INIT_A: begin
        alu_req.a = ffha_pkg::widen(hs_q);
        alu_req.b = ffha_pkg::ROUND_ADD;
      end
      S_INIT_B: begin
        alu_req.a = a_q;
        alu_req.b = ffha_pkg::MIN_W;
        alu_req.c = ffha_pkg::widen(he_q);
      end
      S_INIT_C: begin
        alu_req.a   = ffha_pkg::widen(he_q);
        alu_req.b   = a_q;
        alu_req.sub = 1'b1;
        we          = 1'b1;
        wdata       = {a_q[W-1:0], alu_rsp.r[W-1:0]};
      end
      S_CHK: begin
        alu_req.a = ffha_pkg::widen(usable_q);
        alu_req.c = ffha_pkg::widen(req_q);
      end
      S_SC_RD, S_FR_RD: begin
        re    = (idx_q != count_q);
        raddr = idx_q[IW-1:0];
      end
      S_SC_EV: begin
        alu_req.a = ffha_pkg::widen(req_q);
        alu_req.b = ffha_pkg::MIN_W;
        alu_req.c = ffha_pkg::widen(rd.size);
      end
      S_SC_EV2: begin
        alu_req.a = ffha_pkg::widen(req_q);
        alu_req.c = ffha_pkg::widen(sz_q);
      end
      S_SPL_A, S_PV_A: begin
        alu_req.a = ffha_pkg::widen(st_q);
        alu_req.b = ffha_pkg::widen(sz_q);
      end
      S_SPL_B: begin
        alu_req.a = ffha_pkg::widen(st_q);
        alu_req.b = ffha_pkg::widen(req_q);
      end
      S_SPL_C: begin
        alu_req.a = tmp_q;
        alu_req.b = ffha_pkg::ROUND_ADD;
      end
      S_SPL_D: begin
        alu_req.a = a_q;
        alu_req.b = ffha_pkg::MIN_W;
        alu_req.c = end_q;
        we        = split;
        waddr     = idx_q[IW-1:0];
        wdata     = {st_q, req_q};
      end
      S_SPL_E: begin
        alu_req.a   = end_q;
        alu_req.b   = a_q;
        alu_req.sub = 1'b1;
      end
      S_INS_RD: begin
        if (k_q == idx_p1) begin
          we    = 1'b1;
          waddr = k_q[IW-1:0];
          wdata = {a_q[W-1:0], tmp_q[W-1:0]};
        end else begin
          re    = 1'b1;
          raddr = k_m1[IW-1:0];
        end
      end
      S_INS_WR, S_RM_WR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd;
      end
      S_NX_RD: begin
        re    = 1'b1;
        raddr = idx_p1[IW-1:0];
      end
      S_NX_A: begin
        alu_req.a = ffha_pkg::widen(rd.start);
        alu_req.b = ffha_pkg::widen(rd.size);
      end
      S_NX_B: begin
        alu_req.a   = tmp_q;
        alu_req.b   = ffha_pkg::widen(st_q);
        alu_req.sub = 1'b1;
        we          = 1'b1;
        waddr       = idx_q[IW-1:0];
        wdata       = {st_q, alu_rsp.r[W-1:0]};
      end
      S_RM_RD: begin
        re    = (k_p1 < count_q);
        raddr = k_p1[IW-1:0];
      end
      S_PV_CHK: begin
        re    = (idx_q != '0) && !used_q[idx_m1[IW-1:0]];
        raddr = idx_m1[IW-1:0];
      end
      S_PV_B: begin
        alu_req.a   = tmp_q;
        alu_req.b   = ffha_pkg::widen(rd.start);
        alu_req.sub = 1'b1;
        we          = 1'b1;
        waddr       = idx_m1[IW-1:0];
        wdata       = {rd.start, alu_rsp.r[W-1:0]};
      end
      default: begin
      end
    endcase
  end

  // Sequencer: state, table bookkeeping and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hs_q        <= '0;
      he_q        <= '0;
      usable_q    <= '0;
      ready_q     <= 1'b0;
      count_q     <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      phase_q     <= 1'b0;
      req_q       <= '0;
      faddr_q     <= '0;
      st_q        <= '0;
      sz_q        <= '0;
      a_q         <= '0;
      end_q       <= '0;
      tmp_q       <= '0;
      res_addr_q  <= '0;
      res_stat_q  <= ffha_pkg::STAT_DONE;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_stat_q  <= ffha_pkg::STAT_DONE;
    end else begin
      // Drop the output beat once taken, unless a new result replaces it
      if (res_o.valid && res_o.ready && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_fire) begin
            if (cfg_i.index == ffha_pkg::REG_HEAP_START) begin
              hs_q    <= cfg_i.data;
              state_q <= S_INIT_A;
            end else if (cfg_i.index == ffha_pkg::REG_HEAP_END) begin
              he_q    <= cfg_i.data;
              state_q <= S_INIT_A;
            end
          end else if (cmd_fire) begin
            req_q      <= cmd_i.request_bytes;
            faddr_q    <= cmd_i.free_address;
            idx_q      <= '0;
            res_addr_q <= '0;
            res_stat_q <= ffha_pkg::STAT_REFUSED;
            if (cmd_i.command == ffha_pkg::CMD_ALLOC) begin
              state_q <= (!ready_q || cmd_i.request_bytes == '0) ? S_DONE : S_CHK;
            end else begin
              state_q <= (!ready_q || cmd_i.free_address == '0) ? S_DONE : S_FR_RD;
            end
          end
        end
        // Rebuild the heap as one free block at the aligned start
        S_INIT_A: begin
          a_q     <= alu_rsp.r & ffha_pkg::ALIGN_MASK;
          state_q <= S_INIT_B;
        end
        S_INIT_B: begin
          used_q <= '0;
          if (alu_rsp.lt) begin
            state_q <= S_INIT_C;
          end else begin
            ready_q  <= 1'b0;
            count_q  <= '0;
            usable_q <= '0;
            state_q  <= S_IDLE;
          end
        end
        S_INIT_C: begin
          usable_q <= alu_rsp.r[W-1:0];
          count_q  <= CW'(1);
          ready_q  <= 1'b1;
          state_q  <= S_IDLE;
        end
        // Refuse requests larger than the whole heap
        S_CHK: begin
          state_q <= alu_rsp.lt ? S_DONE : S_SC_RD;
        end
        S_SC_RD: begin
          if (idx_q == count_q) begin
            res_stat_q <= ffha_pkg::STAT_NO_FIT;
            state_q    <= S_DONE;
          end else begin
            state_q <= S_SC_EV;
          end
        end
        S_SC_EV: begin
          st_q <= rd.start;
          sz_q <= rd.size;
          if (used_q[idx_q[IW-1:0]]) begin
            idx_q   <= idx_p1;
            state_q <= S_SC_RD;
          end else if (!alu_rsp.gt) begin
            state_q <= S_SPL_A;
          end else begin
            state_q <= S_SC_EV2;
          end
        end
        S_SC_EV2: begin
          if (!alu_rsp.gt) begin
            used_q[idx_q[IW-1:0]] <= 1'b1;
            res_addr_q            <= st_q;
            res_stat_q            <= ffha_pkg::STAT_DONE;
            state_q               <= S_DONE;
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_SC_RD;
          end
        end
        // Split: block end, remainder data address, then fit check
        S_SPL_A: begin
          end_q   <= alu_rsp.r;
          state_q <= S_SPL_B;
        end
        S_SPL_B: begin
          tmp_q   <= alu_rsp.r;
          state_q <= S_SPL_C;
        end
        S_SPL_C: begin
          a_q     <= alu_rsp.r & ffha_pkg::ALIGN_MASK;
          state_q <= S_SPL_D;
        end
        S_SPL_D: begin
          used_q[idx_q[IW-1:0]] <= 1'b1;
          res_addr_q            <= st_q;
          res_stat_q            <= ffha_pkg::STAT_DONE;
          state_q               <= split ? S_SPL_E : S_DONE;
        end
        S_SPL_E: begin
          tmp_q   <= alu_rsp.r;
          k_q     <= count_q;
          state_q <= S_INS_RD;
        end
        // Shift entries up by one, then drop in the remainder
        S_INS_RD: begin
          if (k_q == idx_p1) begin
            used_q[k_q[IW-1:0]] <= 1'b0;
            count_q             <= count_q + CW'(1);
            state_q             <= S_DONE;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          used_q[k_q[IW-1:0]] <= used_q[k_m1[IW-1:0]];
          k_q                 <= k_m1;
          state_q             <= S_INS_RD;
        end
        // Free: look up a used block at the given data address
        S_FR_RD: begin
          state_q <= (idx_q == count_q) ? S_DONE : S_FR_EV;
        end
        S_FR_EV: begin
          if (rd.start == faddr_q && used_q[idx_q[IW-1:0]]) begin
            st_q                  <= rd.start;
            sz_q                  <= rd.size;
            used_q[idx_q[IW-1:0]] <= 1'b0;
            res_stat_q            <= ffha_pkg::STAT_DONE;
            if (idx_p1 < count_q && !used_q[idx_p1[IW-1:0]]) begin
              state_q <= S_NX_RD;
            end else begin
              state_q <= S_PV_CHK;
            end
          end else begin
            idx_q   <= idx_p1;
            state_q <= S_FR_RD;
          end
        end
        // Merge with the free next block
        S_NX_RD: begin
          state_q <= S_NX_A;
        end
        S_NX_A: begin
          tmp_q   <= alu_rsp.r;
          state_q <= S_NX_B;
        end
        S_NX_B: begin
          sz_q    <= alu_rsp.r[W-1:0];
          k_q     <= idx_p1;
          phase_q <= 1'b0;
          state_q <= S_RM_RD;
        end
        // Close the gap left by the absorbed entry
        S_RM_RD: begin
          if (k_p1 < count_q) begin
            state_q <= S_RM_WR;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= phase_q ? S_DONE : S_PV_CHK;
          end
        end
        S_RM_WR: begin
          used_q[k_q[IW-1:0]] <= used_q[k_p1[IW-1:0]];
          k_q                 <= k_p1;
          state_q             <= S_RM_RD;
        end
        // Merge into the free previous block
        S_PV_CHK: begin
          if (idx_q != '0 && !used_q[idx_m1[IW-1:0]]) begin
            state_q <= S_PV_A;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_PV_A: begin
          tmp_q   <= alu_rsp.r;
          state_q <= S_PV_B;
        end
        S_PV_B: begin
          k_q     <= idx_q;
          phase_q <= 1'b1;
          state_q <= S_RM_RD;
        end
        // Hand the result to the output register once it is free
        S_DONE: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_addr_q;
            out_stat_q  <= res_stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ffha_pkg::MAX_BLOCKS))
    else $error("block count above table depth");

  a_unready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> count_q == '0)
    else $error("table holds blocks while heap is not ready");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |=> !cmd_i.ready)
    else $error("command taken while previous one still in work");

  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_fire && (cfg_i.index == ffha_pkg::REG_HEAP_START ||
                  cfg_i.index == ffha_pkg::REG_HEAP_END)) |=> state_q == S_INIT_A)
    else $error("bound write did not start a rebuild");

endmodule
`default_nettype wire

[sim/ffha_tb_if.sv]
`default_nettype none
interface ffha_tb_clk_if (input logic clk_i);

  // Wait a number of rising clock edges
  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

endinterface
`default_nettype wire

[sim/tb_first_fit_heap_allocator_unit.sv]
`default_nettype none
module tb_first_fit_heap_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  typedef logic [63:0] u64_t;

  // Track heap table state and check each result beat against it
  class heap_scoreboard;
    u64_t hs, he, usable;
    u64_t bstart[MAX_BLOCKS];
    u64_t bsize[MAX_BLOCKS];
    bit   bused[MAX_BLOCKS];
    int   count;
    bit   ready;
    addr_t exp_addr_q[$];
    status_e exp_stat_q[$];
    addr_t live_q[$];
    int   errors;

    function u64_t align_up(u64_t x);
      return ((x + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function void rebuild();
      u64_t d;
      d = align_up(hs + HEADER_BYTES);
      live_q.delete();
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        bused[i] = 0;
      end
      if (d + MIN_BLOCK_BYTES >= he) begin
        ready = 0; count = 0; usable = 0;
      end else begin
        usable = (he - d) & 64'hFFFF_FFFF_FFFF;
        bstart[0] = d; bsize[0] = usable; count = 1; ready = 1;
      end
    endfunction

    function void write_reg(reg_e idx, addr_t v);
      if (idx == REG_HEAP_START) hs = v;
      else he = v;
      rebuild();
    endfunction

    function void drop_entry(int i);
      for (int k = i; k + 1 < count; k++) begin
        bstart[k] = bstart[k+1]; bsize[k] = bsize[k+1]; bused[k] = bused[k+1];
      end
      count--;
    endfunction

    function status_e allocate(u64_t req, output u64_t a);
      u64_t s, e, na;
      a = 0;
      if (!ready || req == 0 || req > usable) return STAT_REFUSED;
      for (int i = 0; i < count; i++) begin
        s = bsize[i];
        if (bused[i]) continue;
        if (s >= req) begin
          if (s >= req + MIN_BLOCK_BYTES) begin
            e = bstart[i] + s;
            na = align_up(bstart[i] + req + HEADER_BYTES);
            if (na + MIN_BLOCK_BYTES < e && count < MAX_BLOCKS) begin
              bsize[i] = req;
              for (int k = count; k > i + 1; k--) begin
                bstart[k] = bstart[k-1]; bsize[k] = bsize[k-1]; bused[k] = bused[k-1];
              end
              bstart[i+1] = na; bsize[i+1] = e - na; bused[i+1] = 0;
              count++;
            end
          end
          bused[i] = 1;
          a = bstart[i];
          return STAT_DONE;
        end
      end
      return STAT_NO_FIT;
    endfunction

    function status_e release_block(u64_t addr);
      int i;
      if (!ready || addr == 0) return STAT_REFUSED;
      for (i = 0; i < count; i++) begin
        if (bstart[i] == addr && bused[i]) break;
      end
      if (i >= count) return STAT_REFUSED;
      bused[i] = 0;
      if (i + 1 < count && !bused[i+1]) begin
        bsize[i] = (bstart[i+1] + bsize[i+1] - bstart[i]) & 64'hFFFF_FFFF_FFFF;
        drop_entry(i + 1);
      end
      if (i > 0 && !bused[i-1]) begin
        bsize[i-1] = (bstart[i] + bsize[i] - bstart[i-1]) & 64'hFFFF_FFFF_FFFF;
        drop_entry(i);
      end
      return STAT_DONE;
    endfunction

    // Note an accepted command beat and queue its expected result
    function void note_command(cmd_e c, addr_t req, addr_t fa);
      u64_t a;
      status_e st;
      a = 0;
      if (c == CMD_ALLOC) begin
        st = allocate(req, a);
        if (st == STAT_DONE) live_q.push_back(addr_t'(a));
      end else begin
        st = release_block(fa);
        if (st == STAT_DONE) begin
          foreach (live_q[j]) if (live_q[j] == fa) begin
            live_q.delete(j);
            break;
          end
        end
      end
      exp_addr_q.push_back(addr_t'(a));
      exp_stat_q.push_back(st);
    endfunction

    // Compare one result beat with the oldest expectation
    function void check_result(addr_t a, logic [1:0] st);
      addr_t ea;
      status_e es;
      if (exp_addr_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result addr=%h status=%0d", a, st);
        return;
      end
      ea = exp_addr_q.pop_front();
      es = exp_stat_q.pop_front();
      if (a !== ea || st !== es) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp addr=%h status=%0d, got addr=%h status=%0d",
                   ea, es, a, st);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  always #4 clk_i = ~clk_i;

  ffha_tb_clk_if clk_if (.clk_i(clk_i));
  ffha_cfg_if cfg_if();
  ffha_cmd_if cmd_if();
  ffha_res_if res_if();

  first_fit_heap_allocator_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  heap_scoreboard heap_sb = new();
  int  hold_cycles = 0;
  bit  hold_tog = 0;
  bit  hold_seen = 0;

  function int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic idle(int n);
    clk_if.wait_cycles(n);
  endtask

  // Write one heap bound and rebuild the predicted table
  task automatic write_bound(reg_e idx, addr_t v);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 0;
    heap_sb.write_reg(idx, v);
    idle(4);
  endtask

  // Send one command beat, holding valid until accepted
  task automatic send_cmd(cmd_e c, addr_t req, addr_t fa, bit nogap);
    cmd_if.valid <= 1; cmd_if.command <= c;
    cmd_if.request_bytes <= req; cmd_if.free_address <= fa;
    do @(posedge clk_i); while (!cmd_if.ready);
    heap_sb.note_command(c, req, fa);
    if (!nogap) begin
      int g;
      g = gap_len();
      if (g > 0) begin
        cmd_if.valid <= 0;
        idle(g);
      end
    end
  endtask

  // Drop valid, then wait for every outstanding result
  task automatic drain();
    cmd_if.valid <= 0;
    while (heap_sb.exp_addr_q.size() != 0) @(posedge clk_i);
    idle(300);
  endtask

  function addr_t rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function addr_t pick_request();
    case ($urandom_range(0, 9))
      0: return rand48();
      1: return addr_t'($urandom_range(1, 4));
      2: return addr_t'($urandom_range(200, 3000));
      default: return addr_t'($urandom_range(1, 160));
    endcase
  endfunction

  function addr_t pick_free();
    int n;
    n = heap_sb.live_q.size();
    case ($urandom_range(0, 9))
      0: return rand48();
      1: return 0;
      2: return (n > 0) ? heap_sb.live_q[0] + 16 : rand48();
      default: return (n > 0) ? heap_sb.live_q[$urandom_range(0, n - 1)] : rand48();
    endcase
  endfunction

  // Random traffic against the current heap bounds
  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0 || heap_sb.live_q.size() == 0)
        send_cmd(CMD_ALLOC, pick_request(), rand48(), 0);
      else
        send_cmd(CMD_FREE, rand48() ^ rand48(), pick_free(), 0);
    end
    drain();
  endtask

  // Accept result beats with random stalls and a requested long hold
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        heap_sb.check_result(res_if.block_address, res_if.status);
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        hold_cycles <= 600;
        res_if.ready <= 0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        res_if.ready <= 0;
      end else if ($urandom_range(0, 29) == 0) begin
        hold_cycles <= $urandom_range(10, 80);
        res_if.ready <= 0;
      end else begin
        res_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    cfg_if.valid = 0; cfg_if.index = REG_HEAP_START; cfg_if.data = 0;
    cmd_if.valid = 0; cmd_if.command = CMD_ALLOC;
    cmd_if.request_bytes = 0; cmd_if.free_address = 0;
    res_if.ready = 0;
    heap_sb.hs = 0; heap_sb.he = 0; heap_sb.errors = 0;
    heap_sb.rebuild();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Heap not ready after reset: everything refused
    send_cmd(CMD_ALLOC, 16, 0, 1);
    send_cmd(CMD_FREE, 0, 48, 1);
    drain();

    // Too small heap, then a boundary-sized heap
    write_bound(REG_HEAP_START, 48'h100);
    write_bound(REG_HEAP_END, 48'h140);
    send_cmd(CMD_ALLOC, 1, 0, 1);
    drain();
    write_bound(REG_HEAP_END, 48'h151);
    send_cmd(CMD_ALLOC, 17, 0, 1);
    send_cmd(CMD_ALLOC, 17, 0, 1);
    drain();

    // Directed: extremes, splits, merges, bad frees, no fit
    write_bound(REG_HEAP_END, 48'h1100);
    send_cmd(CMD_ALLOC, 0, 0, 1);
    send_cmd(CMD_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1);
    send_cmd(CMD_ALLOC, 64, 0, 1);
    send_cmd(CMD_ALLOC, 100, 0, 1);
    send_cmd(CMD_ALLOC, 30, 0, 1);
    send_cmd(CMD_FREE, 0, 48'h130, 1);
    send_cmd(CMD_FREE, 0, 48'h130, 1);
    send_cmd(CMD_FREE, 0, 0, 1);
    send_cmd(CMD_FREE, 0, 48'h1A0, 1);
    send_cmd(CMD_ALLOC, 4000, 0, 1);
    send_cmd(CMD_ALLOC, 3700, 0, 1);
    send_cmd(CMD_FREE, 0, 48'hFFFF_FFFF_FFFF, 1);
    drain();

    // Full table: many tiny allocations, then frees
    write_bound(REG_HEAP_START, 0);
    write_bound(REG_HEAP_END, 48'h2000);
    for (int i = 0; i < 70; i++) send_cmd(CMD_ALLOC, 1, 0, i % 3 == 0);
    drain();
    random_phase(200);

    // Pressure: hold the receiver while commands pile up
    write_bound(REG_HEAP_END, 48'h4000);
    fork
      begin
        @(posedge clk_i);
        hold_tog <= ~hold_tog;
      end
      for (int i = 0; i < 20; i++) send_cmd(CMD_ALLOC, pick_request(), 0, 1);
    join
    drain();

    // Random phases across several bound settings, extremes included
    random_phase(500);
    write_bound(REG_HEAP_START, 48'hFFFF_FFFF_F000);
    write_bound(REG_HEAP_END, 48'hFFFF_FFFF_FFFF);
    random_phase(300);
    write_bound(REG_HEAP_START, 48'h7);
    write_bound(REG_HEAP_END, 48'h1_0000);
    random_phase(500);
    write_bound(REG_HEAP_START, 48'hFFFF_FFFF_FFFF);
    random_phase(30);
    write_bound(REG_HEAP_START, rand48() & 48'h0000_FFFF_FFF0);
    write_bound(REG_HEAP_END, addr_t'(heap_sb.hs + 48'h800));
    random_phase(400);

    if (heap_sb.errors == 0 && heap_sb.exp_addr_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run time
  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_if.sv
hw/rtl/ffha_alu.sv
hw/rtl/ffha_table.sv
hw/rtl/first_fit_heap_allocator_unit.sv
sim/ffha_tb_if.sv
sim/tb_first_fit_heap_allocator_unit.sv
